>>> hdl/bdsl_pkg.sv
// Shared types and constants for the button debounce / press detection block.
package bdsl_pkg;

    localparam int TIME_W = 32;
    localparam int CFG_W  = 16;
    localparam int CFG_IDX_W = 1;
    localparam int EV_W   = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 1'd1;

    localparam logic [CFG_W-1:0] DEBOUNCE_RESET   = 16'd20;
    localparam logic [CFG_W-1:0] LONG_PRESS_RESET = 16'd600;

    // Event codes
    localparam logic [EV_W-1:0] EV_NONE    = 2'd0;
    localparam logic [EV_W-1:0] EV_C_SHORT = 2'd1;
    localparam logic [EV_W-1:0] EV_C_LONG  = 2'd2;
    localparam logic [EV_W-1:0] EV_A_PRESS = 2'd3;

    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic              c_level;
        logic              a_level;
    } poll_t;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_time;
        logic [CFG_W-1:0] long_press_time;
    } cfg_t;

endpackage

>>> hdl/button_debounce_short_long_press_unit.sv
// Top level of the two-button debouncer with short / long press detection.
// Each request is one poll: a millisecond timestamp plus raw levels of
// buttons C and A; each poll yields exactly one event code (0 none, 1 C short
// press, 2 C long press, 3 A press). A poll is captured in an input register,
// evaluated combinationally against the debounce state, and the event lands
// in an output register, so one poll per clock is sustained while the output
// is not stalled. The rate is set by the single evaluation stage (two 32-bit
// subtract-and-compare paths). When the output is stalled the input register
// still takes one more poll before in_stall rises. Configuration (debounce_time
// at index 0, long_press_time at index 1) is written through cfg_we /
// cfg_index / cfg_data and must only change while no poll is in flight.
module button_debounce_short_long_press_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [bdsl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bdsl_pkg::CFG_W-1:0]      cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [bdsl_pkg::TIME_W-1:0]     now_ms,
    input  logic                            c_level,
    input  logic                            a_level,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [bdsl_pkg::EV_W-1:0]       event_code
);
    import bdsl_pkg::*;

    cfg_t             cfg_reg;
    poll_t            poll_reg;
    logic             poll_valid_reg;
    logic             out_valid_reg;
    logic [EV_W-1:0]  event_reg;
    logic [EV_W-1:0]  event_next;
    logic             step;

    // evaluate the held poll whenever the output register is free or draining
    assign step     = poll_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = poll_valid_reg && !step;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.debounce_time   <= DEBOUNCE_RESET;
            cfg_reg.long_press_time <= LONG_PRESS_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_DEBOUNCE:   cfg_reg.debounce_time   <= cfg_data;
                REG_LONG_PRESS: cfg_reg.long_press_time <= cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            poll_valid_reg <= 1'b0;
        end else if (!in_stall) begin
            poll_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall) begin
            poll_reg.now_ms  <= now_ms;
            poll_reg.c_level <= c_level;
            poll_reg.a_level <= a_level;
        end
    end

    bdsl_poll u_poll (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .poll       (poll_reg),
        .cfg        (cfg_reg),
        .event_code (event_next)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (!out_valid_reg || !out_stall) begin
            out_valid_reg <= step;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step) begin
            event_reg <= event_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign event_code = event_reg;

endmodule

>>> hdl/bdsl_poll.sv
// Debounce state and event decision for one poll of buttons C and A.
module bdsl_poll (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       step,
    input  bdsl_pkg::poll_t            poll,
    input  bdsl_pkg::cfg_t             cfg,
    output logic [bdsl_pkg::EV_W-1:0]  event_code
);
    import bdsl_pkg::*;

    logic              c_held_reg, c_held_next;
    logic              a_held_reg, a_held_next;
    logic [TIME_W-1:0] c_edge_time_reg, c_edge_time_next;
    logic [TIME_W-1:0] a_edge_time_reg, a_edge_time_next;
    logic              long_reported_reg, long_reported_next;

    logic [TIME_W-1:0] c_diff;
    logic [TIME_W-1:0] a_diff;
    logic              c_change;
    logic              a_change;
    logic              c_short;
    logic              c_long;
    logic              lr_mid;
    logic              long_due;

    assign c_diff = poll.now_ms - c_edge_time_reg;
    assign a_diff = poll.now_ms - a_edge_time_reg;

    assign c_change = (poll.c_level != c_held_reg) &&
                      (c_diff >= {{(TIME_W-CFG_W){1'b0}}, cfg.debounce_time});
    assign a_change = (poll.a_level != a_held_reg) &&
                      (a_diff >= {{(TIME_W-CFG_W){1'b0}}, cfg.debounce_time});

    // after an accepted C edge the elapsed time restarts at zero
    assign long_due = c_change ? (cfg.long_press_time == '0)
                               : (c_diff >= {{(TIME_W-CFG_W){1'b0}}, cfg.long_press_time});
    assign lr_mid   = (c_change && poll.c_level) ? 1'b0 : long_reported_reg;
    assign c_short  = c_change && !poll.c_level && !long_reported_reg;
    assign c_long   = !c_short && c_held_next && !lr_mid && long_due;

    always_comb
    begin
        c_held_next        = c_change ? poll.c_level : c_held_reg;
        c_edge_time_next   = c_change ? poll.now_ms : c_edge_time_reg;
        long_reported_next = lr_mid | c_long;
        a_held_next        = a_held_reg;
        a_edge_time_next   = a_edge_time_reg;
        event_code         = EV_NONE;
        if (c_short) begin
            event_code = EV_C_SHORT;
        end else if (c_long) begin
            event_code = EV_C_LONG;
        end else if (a_change) begin
            // A is only sampled when C had nothing to say
            a_held_next      = poll.a_level;
            a_edge_time_next = poll.now_ms;
            if (poll.a_level) begin
                event_code = EV_A_PRESS;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            c_held_reg        <= 1'b0;
            a_held_reg        <= 1'b0;
            c_edge_time_reg   <= '0;
            a_edge_time_reg   <= '0;
            long_reported_reg <= 1'b0;
        end else if (step) begin
            c_held_reg        <= c_held_next;
            a_held_reg        <= a_held_next;
            c_edge_time_reg   <= c_edge_time_next;
            a_edge_time_reg   <= a_edge_time_next;
            long_reported_reg <= long_reported_next;
        end
    end

endmodule

>>> tb/press_event_checker.sv
// Checker: predicts the event code of every poll request and compares the block's output.
`timescale 1ns / 100ps

module press_event_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [bdsl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bdsl_pkg::CFG_W-1:0]     cfg_data,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic [bdsl_pkg::TIME_W-1:0]    now_ms,
    input  logic                           c_level,
    input  logic                           a_level,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic [bdsl_pkg::EV_W-1:0]      event_code,
    output int unsigned                    fail_count,
    output int unsigned                    outstanding
);
    import bdsl_pkg::*;

    logic [CFG_W-1:0]  lockout_ms;
    logic [CFG_W-1:0]  long_ms;
    logic              c_down;
    logic              a_down;
    logic [TIME_W-1:0] c_stamp;
    logic [TIME_W-1:0] a_stamp;
    logic              long_done;

    logic [EV_W-1:0]   expected_events[$];

    // One poll: C first; any C event ends the poll before A is looked at.
    function automatic logic [EV_W-1:0] predict_event(input logic [TIME_W-1:0] now,
                                                      input logic c, input logic a);
        logic [EV_W-1:0]   ev;
        logic [TIME_W-1:0] elapsed;
        ev = EV_NONE;
        elapsed = now - c_stamp;
        if (c != c_down && elapsed >= {16'd0, lockout_ms})
        begin
            c_down  = c;
            c_stamp = now;
            if (c)
                long_done = 1'b0;
            else if (!long_done)
                ev = EV_C_SHORT;
        end
        elapsed = now - c_stamp;
        if (ev == EV_NONE && c_down && !long_done && elapsed >= {16'd0, long_ms})
        begin
            long_done = 1'b1;
            ev = EV_C_LONG;
        end
        if (ev == EV_NONE)
        begin
            elapsed = now - a_stamp;
            if (a != a_down && elapsed >= {16'd0, lockout_ms})
            begin
                a_down  = a;
                a_stamp = now;
                if (a)
                    ev = EV_A_PRESS;
            end
        end
        return ev;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [EV_W-1:0] want;
        if (!rst_n)
        begin
            lockout_ms  = DEBOUNCE_RESET;
            long_ms     = LONG_PRESS_RESET;
            c_down      = 1'b0;
            a_down      = 1'b0;
            c_stamp     = '0;
            a_stamp     = '0;
            long_done   = 1'b0;
            expected_events.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_DEBOUNCE)
                    lockout_ms = cfg_data;
                else if (cfg_index == REG_LONG_PRESS)
                    long_ms = cfg_data;
            end
            if (in_valid && !in_stall)
                expected_events.push_back(predict_event(now_ms, c_level, a_level));
            if (out_valid && !out_stall)
            begin
                if (expected_events.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: event_code expected none pending, actual %0d",
                             $time, event_code);
                end
                else
                begin
                    want = expected_events.pop_front();
                    if (event_code !== want)
                    begin
                        fail_count++;
                        $display("%0t: event_code expected %0d, actual %0d",
                                 $time, want, event_code);
                    end
                end
            end
        end
        outstanding = expected_events.size();
    end

endmodule

>>> tb/testbench.sv
// Top of the testbench: clock, reset, poll and register stimulus, verdict.
`timescale 1ns / 100ps

module testbench;
    import bdsl_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_DEBOUNCE;
    logic [CFG_W-1:0]     cfg_data  = '0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    logic [TIME_W-1:0]    now_ms    = '0;
    logic                 c_level   = 1'b0;
    logic                 a_level   = 1'b0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [EV_W-1:0]      event_code;

    int unsigned          fail_count;
    int unsigned          outstanding;
    int unsigned          cycle_count;

    // Running millisecond clock for the random polls.
    logic [TIME_W-1:0]    clock_ms = '0;
    // When set, neither side idles: back-to-back requests and no output stalls.
    logic                 burst_mode = 1'b0;

    // 4 ns period
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    button_debounce_short_long_press_unit DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .now_ms     (now_ms),
        .c_level    (c_level),
        .a_level    (a_level),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .event_code (event_code)
    );

    press_event_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .now_ms      (now_ms),
        .c_level     (c_level),
        .a_level     (a_level),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .event_code  (event_code),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // Issue one poll request. Called right after a rising edge; returns right
    // after the edge that accepted it. Stall is sampled at the falling edge,
    // where everything driven at the rising edge has settled.
    task automatic send_poll(input logic [TIME_W-1:0] t, input logic c, input logic a);
        int unsigned gap;
        logic        busy;
        gap = burst_mode ? 0 : $urandom_range(0, 3);
        if (gap != 0)
        begin
            // junk on the payload while valid is low
            in_valid <= 1'b0;
            now_ms   <= $urandom;
            c_level  <= 1'($urandom_range(0, 1));
            a_level  <= 1'($urandom_range(0, 1));
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        now_ms   <= t;
        c_level  <= c;
        a_level  <= a;
        do
        begin
            @(negedge clk);
            busy = in_stall;
            @(posedge clk);
        end
        while (busy);
    endtask

    // Stop issuing and wait until every predicted event has been taken, then
    // wait for the two-stage pipe to be empty. Ends on a rising edge.
    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Both registers, back to back; write enable stays high across the two.
    task automatic set_config(input logic [CFG_W-1:0] db, input logic [CFG_W-1:0] lp);
        cfg_we    <= 1'b1;
        cfg_index <= REG_DEBOUNCE;
        cfg_data  <= db;
        @(posedge clk);
        cfg_index <= REG_LONG_PRESS;
        cfg_data  <= lp;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Random polls. Mostly gestures: a short bounce burst, then both buttons
    // held at target levels for a while with time moving forward, so that
    // short and long presses and A presses all show up. The rest is noise
    // with time jumps: random, backwards, forward, or right before the wrap.
    task automatic run_phase(input int unsigned polls, input int unsigned step_max);
        int unsigned sent;
        int unsigned bounce;
        int unsigned hold;
        int unsigned i;
        logic        c_tgt;
        logic        a_tgt;
        sent = 0;
        while (sent < polls)
        begin
            burst_mode = ($urandom_range(0, 7) == 0);
            if ($urandom_range(0, 9) < 7)
            begin
                c_tgt  = 1'($urandom_range(0, 1));
                a_tgt  = 1'($urandom_range(0, 1));
                bounce = $urandom_range(0, 3);
                hold   = $urandom_range(1, 12);
                for (i = 0; i < bounce + hold; i++)
                begin
                    if (i < bounce)
                    begin
                        clock_ms += $urandom_range(0, 3);
                        send_poll(clock_ms, 1'($urandom_range(0, 1)),
                                  1'($urandom_range(0, 1)));
                    end
                    else
                    begin
                        clock_ms += $urandom_range(0, step_max);
                        send_poll(clock_ms, c_tgt, a_tgt);
                    end
                end
                sent += bounce + hold;
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0:       clock_ms = $urandom;
                    1:       clock_ms -= $urandom_range(1, 1000);
                    2:       clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 200);
                    default: clock_ms += $urandom_range(0, 3 * step_max);
                endcase
                send_poll(clock_ms, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                sent++;
            end
            // now and then hold off until the pipe is empty
            if ($urandom_range(0, 39) == 0)
                drain();
        end
        burst_mode = 1'b0;
    endtask

    // Output side: draw a random stall per event (none in burst mode), then take one.
    initial
    begin
        int unsigned hold;
        logic        got;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            hold = burst_mode ? 0 : $urandom_range(0, 3);
            if (hold != 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
            begin
                @(negedge clk);
                got = out_valid;
                @(posedge clk);
            end
            while (!got);
        end
    end

    // Watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        int unsigned      p;
        int unsigned      step;
        logic [CFG_W-1:0] db;
        logic [CFG_W-1:0] lp;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, reset values (debounce 20, long press 600).
        send_poll(32'd0,   1'b0, 1'b0);
        send_poll(32'd10,  1'b1, 1'b0);    // C change inside lockout
        send_poll(32'd20,  1'b1, 1'b1);    // C press taken, A press reported
        send_poll(32'd25,  1'b0, 1'b0);    // both locked out
        send_poll(32'd40,  1'b0, 1'b0);    // short press
        send_poll(32'd60,  1'b1, 1'b0);    // C press, A release silent
        send_poll(32'd660, 1'b1, 1'b0);    // long press
        send_poll(32'd700, 1'b0, 1'b1);    // release after long: silent, A press
        send_poll(32'd710, 1'b1, 1'b0);    // locked out
        send_poll(32'd720, 1'b1, 1'b0);
        send_poll(32'd730, 1'b0, 1'b0);
        send_poll(32'd745, 1'b0, 1'b0);    // short press
        send_poll(32'd5,   1'b1, 1'b1);    // time going backwards wraps large
        send_poll(32'hFFFF_FFFF, 1'b0, 1'b0);
        send_poll(32'h0000_0010, 1'b1, 1'b1); // forward across the wrap, small gap
        send_poll(32'h8000_0000, 1'b1, 1'b0);
        send_poll(32'h7FFF_FFFF, 1'b0, 1'b1);
        drain();

        // Directed, zero debounce and zero long press time.
        set_config('0, '0);
        send_poll(32'd100, 1'b1, 1'b0);    // press and long press in one poll
        send_poll(32'd100, 1'b0, 1'b1);    // silent release, A press
        send_poll(32'd100, 1'b1, 1'b1);
        send_poll(32'd100, 1'b0, 1'b0);
        send_poll(32'd101, 1'b1, 1'b0);
        send_poll(32'd101, 1'b0, 1'b1);
        drain();

        clock_ms = 32'd1000;
        for (p = 0; p < 10; p++)
        begin
            case (p)
                0:       begin db = 16'hFFFF; lp = 16'hFFFF; end
                1:       begin db = 16'd0;    lp = 16'hFFFF; end
                2:       begin db = 16'hFFFF; lp = 16'd0;    end
                3:       begin db = 16'd5;    lp = 16'd40;   end
                4:       begin db = 16'd1;    lp = 16'd1;    end
                5:       begin db = DEBOUNCE_RESET; lp = LONG_PRESS_RESET; end
                6, 7:    begin
                             db = CFG_W'($urandom_range(0, 40));
                             lp = CFG_W'($urandom_range(0, 800));
                         end
                8:       begin db = CFG_W'($urandom); lp = CFG_W'($urandom); end
                default: begin db = 16'd0;    lp = CFG_W'($urandom_range(0, 100)); end
            endcase
            set_config(db, lp);
            // time steps scaled so that holds reach the long press time
            step = ((db > lp) ? db : lp) / 6 + 4;
            run_phase(150, step);
            drain();
        end

        repeat (8) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
